@@ sv/shared_exponent_triple_codec_core_defines.svh @@
// Assertion macros shared by the shared-exponent codec RTL.
`ifndef SHARED_EXPONENT_TRIPLE_CODEC_CORE_DEFINES_SVH
`define SHARED_EXPONENT_TRIPLE_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SETC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, checked outside of reset.
`define SETC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

@@ sv/setc_pkg.sv @@
// Package with the shared types and constants of the shared-exponent codec.
package setc_pkg;

    // Request type codes.
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Bit pattern of 1e-9 in single precision; positive floats order like integers.
    localparam logic [31:0] ENC_THRESHOLD_BITS = 32'h3089_705F;

    // Payload of one request.
    typedef struct packed {
        logic        req_type;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [31:0] packed_word;
    } setc_req_t;

    // Payload of one result.
    typedef struct packed {
        logic [31:0] packed_out;
        logic [31:0] x_out;
        logic [31:0] y_out;
        logic [31:0] z_out;
    } setc_rsp_t;

endpackage

@@ sv/setc_if.sv @@
// Handshake interfaces for the request and result channels of the codec.
interface setc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic [31:0] packed_word;

    modport source (output valid, output req_type, output x_bits, output y_bits,
                    output z_bits, output packed_word, input ready);
    modport sink (input valid, input req_type, input x_bits, input y_bits,
                  input z_bits, input packed_word, output ready);
endinterface

interface setc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_out;
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [31:0] z_out;

    modport source (output valid, output packed_out, output x_out, output y_out,
                    output z_out, input ready);
    modport sink (input valid, input packed_out, input x_out, input y_out,
                  input z_out, output ready);
endinterface

@@ sv/shared_exponent_triple_codec_core.sv @@
// Shared-exponent codec: three singles to and from one 32-bit word, one request per clock;
// each request passes an input register, the encode/decode logic and a result register, so
// its result is presented from the result register, and a new request is taken every
// cycle that the result side does not stall.
`include "shared_exponent_triple_codec_core_defines.svh"

module shared_exponent_triple_codec_core (
    input logic     clk,
    input logic     rst_n,
    setc_req_if.sink   in_req,
    setc_rsp_if.source out_rsp
);
    import setc_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    setc_req_t s1_req_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    setc_rsp_t out_rsp_reg;
    setc_rsp_t rsp_c;
    logic      out_free;
    logic      s1_adv;
    logic      in_take;

    // Stage handshakes: a stage takes a request when it is empty or draining.
    assign out_free     = !out_valid_reg || out_rsp.ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign in_req.ready = !s1_valid_reg || out_free;
    assign in_take      = in_req.valid && in_req.ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !out_rsp.ready);

    // Datapath between the two registers.
    setc_codec u_codec (
        .req (s1_req_reg),
        .rsp (rsp_c)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg.req_type    <= in_req.req_type;
            s1_req_reg.x_bits      <= in_req.x_bits;
            s1_req_reg.y_bits      <= in_req.y_bits;
            s1_req_reg.z_bits      <= in_req.z_bits;
            s1_req_reg.packed_word <= in_req.packed_word;
        end
        if (s1_adv)
            out_rsp_reg <= rsp_c;
    end

    assign out_rsp.valid      = out_valid_reg;
    assign out_rsp.packed_out = out_rsp_reg.packed_out;
    assign out_rsp.x_out      = out_rsp_reg.x_out;
    assign out_rsp.y_out      = out_rsp_reg.y_out;
    assign out_rsp.z_out      = out_rsp_reg.z_out;

    // A full pipeline with a stalled result must refuse new requests.
    `SETC_ASSERT_IMPL(a_full_stall, clk, rst_n, s1_valid_reg && out_valid_reg && !out_rsp.ready, !in_req.ready)
    // A decode request leaves the encoded word at zero.
    `SETC_ASSERT_NEXT(a_dec_word_zero, clk, rst_n, s1_adv && s1_req_reg.req_type == REQ_DECODE, out_rsp.packed_out == 32'd0)
    // An encode request leaves the decoded x and z values at zero.
    `SETC_ASSERT_NEXT(a_enc_vals_zero, clk, rst_n, s1_adv && s1_req_reg.req_type == REQ_ENCODE, out_rsp.x_out == 32'd0 && out_rsp.z_out == 32'd0)

endmodule

@@ sv/setc_codec.sv @@
// Combinational encode and decode datapath between the input and result registers.
module setc_codec (
    input  setc_pkg::setc_req_t req,
    output setc_pkg::setc_rsp_t rsp
);
    import setc_pkg::*;

    // Negative values and NaN become positive zero.
    function automatic logic [31:0] clamp_pos(input logic [31:0] b);
        logic [31:0] r;
        r = b;
        if (b[31])
            r = 32'd0;
        else if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
            r = 32'd0;
        return r;
    endfunction

    // floor(v * 2^(134 - e)) for the largest value's biased exponent e.
    function automatic logic [7:0] enc_byte(input logic [31:0] b, input logic [7:0] big_exp);
        logic [7:0]  ex;
        logic [23:0] sig;
        logic [7:0]  diff;
        logic [4:0]  sh;
        logic [23:0] shifted;
        ex  = b[30:23];
        sig = {1'b1, b[22:0]};
        if (ex == 8'd0)
        begin
            ex  = 8'd1;
            sig = {1'b0, b[22:0]};
        end
        diff    = big_exp - ex;
        sh      = diff[4:0] + 5'd16;
        shifted = sig >> sh;
        if (diff > 8'd15)
            return 8'd0;
        return shifted[7:0];
    endfunction

    // Single bits of (byte + 0.5) * 2^(e - 136), e nonzero.
    function automatic logic [31:0] dec_value(input logic [7:0] mbyte, input logic [7:0] e);
        logic [8:0]         n;
        logic [3:0]         p;
        logic signed [10:0] bexp;
        logic [31:0]        wide;
        logic [4:0]         sh;
        n = {mbyte, 1'b1};
        p = 4'd0;
        for (int i = 1; i < 9; i++)
        begin
            if (n[i])
                p = 4'(i);
        end
        bexp = $signed({7'b0, p}) + $signed({3'b0, e}) - 11'sd10;
        if (bexp >= 11'sd1)
        begin
            wide = {23'd0, n} << (5'd23 - {1'b0, p});
            return {1'b0, bexp[7:0], wide[22:0]};
        end
        // Subnormal result: only reached for small exponents.
        sh = e[4:0] + 5'd12;
        return {23'd0, n} << sh;
    endfunction

    logic [31:0] x_c;
    logic [31:0] y_c;
    logic [31:0] z_c;
    logic [31:0] big;
    logic [7:0]  big_exp;
    logic [31:0] enc_word;
    logic [7:0]  dec_exp;

    // Encode: clamp, pick the largest, scale each byte by the largest's exponent.
    always_comb
    begin
        x_c = clamp_pos(req.x_bits);
        y_c = clamp_pos(req.y_bits);
        z_c = clamp_pos(req.z_bits);
        big = x_c;
        if (y_c > big)
            big = y_c;
        if (z_c > big)
            big = z_c;
        big_exp = big[30:23];
        if (big < ENC_THRESHOLD_BITS)
            enc_word = 32'd0;
        else if (big_exp >= 8'd254)
            enc_word = 32'hFFFF_FFFF;
        else
            enc_word = {enc_byte(x_c, big_exp), enc_byte(y_c, big_exp),
                        enc_byte(z_c, big_exp), big_exp + 8'd2};
    end

    // Decode or encode result, with the unused fields held at zero.
    always_comb
    begin
        dec_exp = req.packed_word[7:0];
        rsp     = '0;
        unique case (req.req_type)
            REQ_ENCODE:
            begin
                rsp.packed_out = enc_word;
            end
            REQ_DECODE:
            begin
                if (dec_exp != 8'd0)
                begin
                    rsp.x_out = dec_value(req.packed_word[31:24], dec_exp);
                    rsp.y_out = dec_value(req.packed_word[23:16], dec_exp);
                    rsp.z_out = dec_value(req.packed_word[15:8], dec_exp);
                end
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

endmodule
